/* hdl/ssrs_pkg.sv */
// Shared types, constants and helper functions for the seven-segment readout scanner.
// Depends on nothing; used by the front, queue, back and top-level modules.
`default_nettype none
package ssrs_pkg;

	localparam int DIGIT_COUNT = 6;
	localparam int CODE_W      = 5;
	localparam int SEL_W       = 3;
	localparam int SEG_W       = 8;
	localparam int TEMP_W      = 11;
	localparam int HUM_W       = 16;
	localparam int MAG_W       = 10;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CODE_W-1:0] CODE_MINUS = 5'd10;
	localparam logic [CODE_W-1:0] CODE_BLANK = 5'd16;
	localparam logic [SEG_W-1:0]  DOT_BIT    = 8'h80;
	localparam logic [HUM_W-1:0]  HUM_ERROR  = 16'hffff;
	localparam logic [HUM_W-1:0]  HUM_MAX    = 16'd999;
	localparam logic signed [TEMP_W-1:0] TEMP_MAX = 11'sd999;
	localparam logic signed [TEMP_W-1:0] TEMP_MIN = -11'sd999;
	localparam logic [SEL_W-1:0]  SEL_LAST   = 3'(DIGIT_COUNT - 1);
	localparam logic [SEL_W-1:0]  SEL_DOT_FIX = 3'd4;
	localparam logic [SEL_W-1:0]  SEL_DOT_TEMP = 3'd1;

	typedef enum logic {
		REQ_UPDATE = 1'b0,
		REQ_TICK   = 1'b1
	} req_kind_t;

	typedef struct packed {
		req_kind_t                          kind;
		logic                               dot;
		logic [DIGIT_COUNT-1:0][CODE_W-1:0] codes;
	} entry_t;

	typedef struct packed {
		logic [3:0] hund;
		logic [3:0] tens;
		logic [3:0] units;
	} bcd3_t;

	// Split a value below 1000 into decimal digits by reciprocal multiplies.
	function automatic bcd3_t split_dec(input logic [MAG_W-1:0] v);
		logic [15:0] p100;
		logic [3:0]  q100;
		logic [MAG_W-1:0] r100;
		logic [13:0] p10;
		logic [3:0]  q10;
		logic [6:0]  r7;
		bcd3_t       d;
		p100  = 16'(v) * 16'd41;
		q100  = p100[15:12];
		r100  = v - 10'(q100) * 10'd100;
		r7    = r100[6:0];
		p10   = 14'(r7) * 14'd103;
		q10   = p10[13:10];
		d.hund  = q100;
		d.tens  = q10;
		d.units = 4'(r7 - 7'(q10) * 7'd10);
		return d;
	endfunction

	function automatic logic [SEG_W-1:0] seg_of(input logic [CODE_W-1:0] code);
		logic [SEG_W-1:0] s;
		case (code)
			5'd0:    s = 8'h3f;
			5'd1:    s = 8'h06;
			5'd2:    s = 8'h5b;
			5'd3:    s = 8'h4f;
			5'd4:    s = 8'h66;
			5'd5:    s = 8'h6d;
			5'd6:    s = 8'h7d;
			5'd7:    s = 8'h07;
			5'd8:    s = 8'h7f;
			5'd9:    s = 8'h6f;
			5'd10:   s = 8'h40;
			5'd11:   s = 8'h79;
			5'd12:   s = 8'h50;
			5'd13:   s = 8'h5c;
			5'd14:   s = 8'h39;
			5'd15:   s = 8'h76;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

endpackage
`default_nettype wire

/* hdl/seven_segment_readout_scanner.sv */
// With an empty queue a tick passes through the queue and then the output register before
// its segment byte is valid on m_axis; updates give no output.
// Throughput: one item per cycle while m_axis accepts; with m_axis held off, the output
// register and two queued entries fill before s_axis_tready drops.
// Reset: arst_n clears digit codes to zero, dot flag and scan position to zero, queue empty.
// Top level: ssrs_front -> ssrs_queue -> ssrs_back; depends on ssrs_pkg.
`default_nettype none
module seven_segment_readout_scanner (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output      logic        s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // temp_value[10:0], hum_value[26:11], zero pad
	input  wire logic        s_axis_tuser,  // req_type
	output      logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output      logic [15:0] m_axis_tdata   // segment_pattern[7:0], digit_select[10:8], zero pad
);

	logic                             push_valid;
	logic                             push_ready;
	ssrs_pkg::entry_t                 push_entry;
	logic                             pop_valid;
	logic                             pop_ready;
	ssrs_pkg::entry_t                 pop_entry;
	logic [ssrs_pkg::QCNT_W-1:0]      q_count;
	logic [ssrs_pkg::SEG_W-1:0]       segment_pattern;
	logic [ssrs_pkg::SEL_W-1:0]       digit_select;

	ssrs_front u_front (
		.in_valid   (s_axis_tvalid),
		.in_kind    (s_axis_tuser),
		.temp_value (s_axis_tdata[10:0]),
		.hum_value  (s_axis_tdata[26:11]),
		.push_valid (push_valid),
		.push_entry (push_entry)
	);

	ssrs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry),
		.count      (q_count)
	);

	ssrs_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.pop_valid       (pop_valid),
		.pop_ready       (pop_ready),
		.pop_entry       (pop_entry),
		.out_valid       (m_axis_tvalid),
		.out_ready       (m_axis_tready),
		.segment_pattern (segment_pattern),
		.digit_select    (digit_select)
	);

	assign s_axis_tready = push_ready;
	assign m_axis_tdata  = {5'd0, digit_select, segment_pattern};

	a_sel_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[10:8] <= ssrs_pkg::SEL_LAST))
		else $error("digit_select out of range");

	a_fixed_dot: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[10:8] == ssrs_pkg::SEL_DOT_FIX) |-> m_axis_tdata[7])
		else $error("dot missing on fixed-dot digit");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= ssrs_pkg::QCNT_W'(ssrs_pkg::QUEUE_DEPTH))
		else $error("queue count overflow");

	a_out_from_tick: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(pop_valid && pop_ready
			&& pop_entry.kind == ssrs_pkg::REQ_TICK))
		else $error("output raised without a tick");

endmodule
`default_nettype wire

/* hdl/ssrs_front.sv */
// Front part: classifies incoming items and turns readings into six digit codes.
// Depends on ssrs_pkg; feeds ssrs_queue.
`default_nettype none
module ssrs_front (
	input  wire logic                                 in_valid,
	input  wire logic                                 in_kind,
	input  wire logic signed [ssrs_pkg::TEMP_W-1:0]   temp_value,
	input  wire logic        [ssrs_pkg::HUM_W-1:0]    hum_value,
	output      logic                                 push_valid,
	output      ssrs_pkg::entry_t                     push_entry
);

	logic signed [ssrs_pkg::TEMP_W-1:0] t_sat;
	logic                               neg;
	logic [ssrs_pkg::MAG_W-1:0]         t_mag;
	logic [ssrs_pkg::HUM_W-1:0]         h_sat;
	ssrs_pkg::bcd3_t                    t_dig;
	ssrs_pkg::bcd3_t                    h_dig;

	always_comb begin
		if (temp_value > ssrs_pkg::TEMP_MAX) begin
			t_sat = ssrs_pkg::TEMP_MAX;
		end else if (temp_value < ssrs_pkg::TEMP_MIN) begin
			t_sat = ssrs_pkg::TEMP_MIN;
		end else begin
			t_sat = temp_value;
		end
		neg   = t_sat[ssrs_pkg::TEMP_W-1];
		t_mag = neg ? ssrs_pkg::MAG_W'(-t_sat) : ssrs_pkg::MAG_W'(t_sat);
		h_sat = (hum_value > ssrs_pkg::HUM_MAX) ? ssrs_pkg::HUM_MAX : hum_value;
		t_dig = ssrs_pkg::split_dec(t_mag);
		h_dig = ssrs_pkg::split_dec(h_sat[ssrs_pkg::MAG_W-1:0]);

		push_entry.kind = ssrs_pkg::req_kind_t'(in_kind);
		push_entry.dot  = !neg;
		if (neg) begin
			push_entry.codes[0] = ssrs_pkg::CODE_MINUS;
			push_entry.codes[1] = (t_dig.hund == 4'd0) ? ssrs_pkg::CODE_BLANK
				: ssrs_pkg::CODE_W'(t_dig.hund);
			push_entry.codes[2] = ssrs_pkg::CODE_W'(t_dig.tens);
		end else begin
			push_entry.codes[0] = (t_dig.hund == 4'd0) ? ssrs_pkg::CODE_BLANK
				: ssrs_pkg::CODE_W'(t_dig.hund);
			push_entry.codes[1] = ssrs_pkg::CODE_W'(t_dig.tens);
			push_entry.codes[2] = ssrs_pkg::CODE_W'(t_dig.units);
		end
		push_entry.codes[3] = ssrs_pkg::CODE_W'(h_dig.hund);
		push_entry.codes[4] = ssrs_pkg::CODE_W'(h_dig.tens);
		push_entry.codes[5] = ssrs_pkg::CODE_W'(h_dig.units);
		// sensor error: dashes on every digit, dot flag stays as temperature set it
		if (hum_value == ssrs_pkg::HUM_ERROR) begin
			for (int i = 0; i < ssrs_pkg::DIGIT_COUNT; i++) begin
				push_entry.codes[i] = ssrs_pkg::CODE_MINUS;
			end
		end
		push_valid = in_valid;
	end

endmodule
`default_nettype wire

/* hdl/ssrs_queue.sv */
// Short queue of classified entries between the front and back parts.
// Depends on ssrs_pkg for the entry type and depth.
`default_nettype none
module ssrs_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	output      logic             push_ready,
	input  wire ssrs_pkg::entry_t push_entry,
	output      logic             pop_valid,
	input  wire logic             pop_ready,
	output      ssrs_pkg::entry_t pop_entry,
	output      logic [ssrs_pkg::QCNT_W-1:0] count
);

	ssrs_pkg::entry_t                mem_q [ssrs_pkg::QUEUE_DEPTH];
	logic [ssrs_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [ssrs_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [ssrs_pkg::QCNT_W-1:0]     count_q;
	logic                            do_push;
	logic                            do_pop;

	assign push_ready = (count_q != ssrs_pkg::QCNT_W'(ssrs_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_entry  = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign count      = count_q;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == ssrs_pkg::QPTR_W'(ssrs_pkg::QUEUE_DEPTH - 1))
					? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == ssrs_pkg::QPTR_W'(ssrs_pkg::QUEUE_DEPTH - 1))
					? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

/* hdl/ssrs_back.sv */
// Back part: holds digit codes and scan position, emits one segment byte per tick.
// Depends on ssrs_pkg; drains ssrs_queue and drives the output register.
`default_nettype none
module ssrs_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          pop_valid,
	output      logic                          pop_ready,
	input  wire ssrs_pkg::entry_t              pop_entry,
	output      logic                          out_valid,
	input  wire logic                          out_ready,
	output      logic [ssrs_pkg::SEG_W-1:0]    segment_pattern,
	output      logic [ssrs_pkg::SEL_W-1:0]    digit_select
);

	logic [ssrs_pkg::DIGIT_COUNT-1:0][ssrs_pkg::CODE_W-1:0] codes_q;
	logic                           dot_q;
	logic [ssrs_pkg::SEL_W-1:0]     scan_q;
	logic                           out_valid_q;
	logic [ssrs_pkg::SEG_W-1:0]     seg_q;
	logic [ssrs_pkg::SEL_W-1:0]     sel_q;
	logic [ssrs_pkg::SEL_W-1:0]     scan_next;
	logic [ssrs_pkg::SEG_W-1:0]     seg_next;
	logic                           is_tick;
	logic                           take;

	assign is_tick   = (pop_entry.kind == ssrs_pkg::REQ_TICK);
	// updates drain at once; ticks wait for room in the output register
	assign pop_ready = !is_tick || !out_valid_q || out_ready;
	assign take      = pop_valid && pop_ready;

	always_comb begin
		scan_next = (scan_q >= ssrs_pkg::SEL_LAST) ? '0 : scan_q + 1'b1;
		seg_next  = ssrs_pkg::seg_of(codes_q[scan_next]);
		if (scan_next == ssrs_pkg::SEL_DOT_FIX
			|| (scan_next == ssrs_pkg::SEL_DOT_TEMP && dot_q)) begin
			seg_next = seg_next | ssrs_pkg::DOT_BIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codes_q     <= '0;
			dot_q       <= 1'b0;
			scan_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take && !is_tick) begin
				codes_q <= pop_entry.codes;
				dot_q   <= pop_entry.dot;
			end
			if (take && is_tick) begin
				scan_q      <= scan_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && is_tick) begin
			seg_q <= seg_next;
			sel_q <= scan_next;
		end
	end

	assign out_valid       = out_valid_q;
	assign segment_pattern = seg_q;
	assign digit_select    = sel_q;

endmodule
`default_nettype wire
